/* rtl/kbdp_pkg.sv */
package kbdp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOUR = 1'b1;

    // Configuration widths and reset values
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_W     = 7;
    localparam int PIX_W      = 24;
    localparam int CHAN_W     = 8;
    localparam logic [SIZE_W-1:0] OUT_SIZE_RESET   = 7'd16;
    localparam logic [PIX_W-1:0]  KEY_COLOUR_RESET = 24'hFF00FF;

    // Smallest usable output side
    localparam int MIN_OUT_SIZE = 4;

    // Alpha contribution of one opaque source pixel
    localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hFF;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // One queued result: last flag, alpha, red, green, blue
    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } res_t;

endpackage

/* rtl/keyed_box_downsample_premul.sv */
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// pix      | pix_valid/pix_stall | src_pixel[23:0], image_start
// res      | res_valid/res_stall | alpha, red, green, blue [7:0], last_of_image
// cfg      | cfg_valid/cfg_ready | cfg_index[0], cfg_data[23:0]
//
// One source pixel per clock unless stalled. A result leaves after its block's
// last pixel: line store read, sum and write back, divide by SCALE^2 into the
// queue. The line store read/modify/write loop forwards the value written in
// the same cycle, so pixels of one block column follow each other with no gap.
// Input stalls only while the 4-entry result queue plus results in flight is
// full; it depends on registers only. Reset clears counters, config and queue;
// the line store has no reset and needs no clearing pass.
module keyed_box_downsample_premul
    import kbdp_pkg::*;
#(
    parameter int SCALE        = 4,
    parameter int MAX_OUT_SIZE = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [PIX_W-1:0]      src_pixel,
    input  logic                  image_start,

    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [CHAN_W-1:0]     alpha,
    output logic [CHAN_W-1:0]     red,
    output logic [CHAN_W-1:0]     green,
    output logic [CHAN_W-1:0]     blue,
    output logic                  last_of_image
);

    localparam int AREA      = SCALE * SCALE;
    localparam int SUB_W     = $clog2(SCALE);
    localparam int ADDR_W    = $clog2(MAX_OUT_SIZE);
    localparam int N_W       = $clog2(MAX_OUT_SIZE + 1);
    localparam int CMP_W     = (N_W > SIZE_W) ? N_W : SIZE_W;
    localparam int SUM_W     = $clog2(255 * AREA + 1);
    localparam int LINE_W    = 4 * SUM_W;
    // floor(s / AREA) = (s * DIV_MUL) >> DIV_SHIFT for every s below 2^SUM_W
    localparam int DIV_SHIFT = SUM_W + 7;
    localparam int DIV_MUL   = ((1 << DIV_SHIFT) + AREA - 1) / AREA;
    localparam int MUL_W     = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MUL_W;

    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SCALE - 1);

    // Configuration registers
    logic [SIZE_W-1:0] out_size_reg;
    logic [PIX_W-1:0]  key_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_size_reg <= OUT_SIZE_RESET;
            key_reg      <= KEY_COLOUR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OUT_SIZE:   out_size_reg <= cfg_data[SIZE_W-1:0];
                REG_KEY_COLOUR: key_reg      <= cfg_data[PIX_W-1:0];
                default:        ;
            endcase
        end
    end

    // Effective output side, clamped to the supported range
    logic [CMP_W-1:0] size_ext;
    logic [N_W-1:0]   n_eff;
    logic [N_W-1:0]   n_last;

    always_comb
    begin
        size_ext = CMP_W'(out_size_reg);
        if (size_ext < CMP_W'(MIN_OUT_SIZE))
            n_eff = N_W'(MIN_OUT_SIZE);
        else if (size_ext > CMP_W'(MAX_OUT_SIZE))
            n_eff = N_W'(MAX_OUT_SIZE);
        else
            n_eff = N_W'(size_ext);
        n_last = n_eff - N_W'(1);
    end

    // Position counters: output column/row and offset inside the block
    logic [ADDR_W-1:0] col_o_reg, col_o_next;
    logic [SUB_W-1:0]  col_i_reg, col_i_next;
    logic [ADDR_W-1:0] row_o_reg, row_o_next;
    logic [SUB_W-1:0]  row_j_reg, row_j_next;

    logic              accept;
    logic              restart;
    logic [ADDR_W-1:0] c_o, r_o;
    logic [SUB_W-1:0]  c_i, r_j;
    logic              blk_first, blk_last, img_end, opaque;

    assign accept = pix_valid && !pix_stall;

    always_comb
    begin
        restart = image_start
               || (N_W'(col_o_reg) >= n_eff)
               || (N_W'(row_o_reg) >= n_eff);
        c_o = restart ? '0 : col_o_reg;
        c_i = restart ? '0 : col_i_reg;
        r_o = restart ? '0 : row_o_reg;
        r_j = restart ? '0 : row_j_reg;

        blk_first = (c_i == '0) && (r_j == '0);
        blk_last  = (c_i == SUB_LAST) && (r_j == SUB_LAST);
        img_end   = (N_W'(c_o) == n_last) && (N_W'(r_o) == n_last);
        opaque    = (src_pixel != key_reg);

        // raster advance
        col_o_next = c_o;
        col_i_next = c_i + SUB_W'(1);
        row_o_next = r_o;
        row_j_next = r_j;
        if (c_i == SUB_LAST)
        begin
            col_i_next = '0;
            if (N_W'(c_o) == n_last)
            begin
                col_o_next = '0;
                if (r_j == SUB_LAST)
                begin
                    row_j_next = '0;
                    row_o_next = (N_W'(r_o) == n_last) ? '0 : r_o + ADDR_W'(1);
                end
                else
                begin
                    row_j_next = r_j + SUB_W'(1);
                end
            end
            else
            begin
                col_o_next = c_o + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_o_reg <= '0;
            col_i_reg <= '0;
            row_o_reg <= '0;
            row_j_reg <= '0;
        end
        else if (accept)
        begin
            col_o_reg <= col_o_next;
            col_i_reg <= col_i_next;
            row_o_reg <= row_o_next;
            row_j_reg <= row_j_next;
        end
    end

    // Stage 1: line store read is in flight, pixel info waits here
    logic              s1_valid_reg;
    logic              s1_res_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_first_reg;
    logic              s1_end_reg;
    logic              s1_opaque_reg;
    logic [PIX_W-1:0]  s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_res_reg   <= accept && blk_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= c_o;
            s1_first_reg  <= blk_first;
            s1_end_reg    <= img_end;
            s1_opaque_reg <= opaque;
            s1_pix_reg    <= src_pixel;
        end
    end

    // Line store: partial sums per output column, {alpha, red, green, blue}
    logic [LINE_W-1:0] line_mem [MAX_OUT_SIZE];
    logic [LINE_W-1:0] rd_data_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;
    logic [LINE_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_mem[c_o];
        if (s1_valid_reg)
            line_mem[s1_addr_reg] <= wr_data;
    end

    // Bypass the write that lands on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else
            fwd_hit_reg <= s1_valid_reg && (s1_addr_reg == c_o);
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    // Accumulate this pixel into its column sums
    logic [LINE_W-1:0] old_sum;
    logic [SUM_W-1:0]  add_a, add_r, add_g, add_b;

    always_comb
    begin
        if (s1_first_reg)
            old_sum = '0;
        else if (fwd_hit_reg)
            old_sum = fwd_data_reg;
        else
            old_sum = rd_data_reg;

        add_a = s1_opaque_reg ? SUM_W'(OPAQUE_ALPHA) : '0;
        add_r = s1_opaque_reg ? SUM_W'(s1_pix_reg[23:16]) : '0;
        add_g = s1_opaque_reg ? SUM_W'(s1_pix_reg[15:8]) : '0;
        add_b = s1_opaque_reg ? SUM_W'(s1_pix_reg[7:0]) : '0;

        wr_data = { old_sum[3*SUM_W +: SUM_W] + add_a,
                    old_sum[2*SUM_W +: SUM_W] + add_r,
                    old_sum[1*SUM_W +: SUM_W] + add_g,
                    old_sum[0*SUM_W +: SUM_W] + add_b };
    end

    // Stage 2: finished block sums
    logic              s2_valid_reg;
    logic [LINE_W-1:0] s2_sum_reg;
    logic              s2_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_res_reg)
        begin
            s2_sum_reg <= wr_data;
            s2_end_reg <= s1_end_reg;
        end
    end

    // Divide by SCALE^2 through the reciprocal
    logic [PROD_W-1:0] prod [4];
    res_t              push_res;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            prod[k] = PROD_W'(s2_sum_reg[k*SUM_W +: SUM_W]) * PROD_W'(DIV_MUL);
        push_res.last = s2_end_reg;
        push_res.a    = prod[3][DIV_SHIFT +: CHAN_W];
        push_res.r    = prod[2][DIV_SHIFT +: CHAN_W];
        push_res.g    = prod[1][DIV_SHIFT +: CHAN_W];
        push_res.b    = prod[0][DIV_SHIFT +: CHAN_W];
    end

    // Result queue
    res_t                  fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic                  pop;
    logic [FIFO_CNT_W:0]   occupancy;

    assign pop = res_valid && !res_stall;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
            fifo_mem[wr_ptr_reg] <= push_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (s2_valid_reg)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            priority if (s2_valid_reg && !pop)
                fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(1);
            else if (pop && !s2_valid_reg)
                fifo_cnt_reg <= fifo_cnt_reg - FIFO_CNT_W'(1);
        end
    end

    // Hold input while the queue could not take every result in flight
    assign occupancy = (FIFO_CNT_W+1)'(fifo_cnt_reg)
                     + (FIFO_CNT_W+1)'(s1_valid_reg && s1_res_reg)
                     + (FIFO_CNT_W+1)'(s2_valid_reg);
    assign pix_stall = (occupancy >= (FIFO_CNT_W+1)'(FIFO_DEPTH));

    assign res_valid     = (fifo_cnt_reg != '0);
    assign alpha         = fifo_mem[rd_ptr_reg].a;
    assign red           = fifo_mem[rd_ptr_reg].r;
    assign green         = fifo_mem[rd_ptr_reg].g;
    assign blue          = fifo_mem[rd_ptr_reg].b;
    assign last_of_image = fifo_mem[rd_ptr_reg].last;

    // Checks
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_valid_reg && !pop && (fifo_cnt_reg == FIFO_CNT_W'(FIFO_DEPTH))))
        else $error("result pushed into full queue");

    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_i_reg <= SUB_LAST) && (row_j_reg <= SUB_LAST))
        else $error("block offset counter out of range");

    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_res_reg) |=> s2_valid_reg)
        else $error("block result lost between stages");

endmodule
